FILE: hdl/ptwa_pkg.sv
`timescale 1ns / 1ps

package ptwa_pkg;

	localparam int CMD_W   = 3;
	localparam int PAGE_W  = 8;
	localparam int FRAME_W = 6;
	localparam int AGE_W   = 8;

	// pages the page field can name at all
	localparam int PAGE_SPAN = 2 ** PAGE_W;

	// frames a map may store
	localparam int unsigned FRAMES = 64;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
	localparam logic [CMD_W-1:0] CMD_MAP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UNMAP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REF    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_AGE    = 3'd4;

	typedef struct packed {
		logic               valid;
		logic               has_frame;
		logic [FRAME_W-1:0] frame;
		logic               referenced;
		logic [AGE_W-1:0]   age;
	} entry_t;

	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame_out;
		logic               frame_assigned;
		logic               referenced;
		logic [AGE_W-1:0]   age_value;
	} result_t;

endpackage

FILE: hdl/ptwa_if.sv
`timescale 1ns / 1ps

interface ptwa_req_if;
	import ptwa_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [PAGE_W-1:0]  page;
	logic [FRAME_W-1:0] frame_in;

	modport source (output valid, command, page, frame_in, input ready);
	modport sink (input valid, command, page, frame_in, output ready);
endinterface

interface ptwa_rsp_if;
	import ptwa_pkg::*;

	logic               valid;
	logic               ready;
	logic               hit;
	logic [FRAME_W-1:0] frame_out;
	logic               frame_assigned;
	logic               referenced;
	logic [AGE_W-1:0]   age_value;

	modport source (output valid, hit, frame_out, frame_assigned, referenced, age_value,
		input ready);
	modport sink (input valid, hit, frame_out, frame_assigned, referenced, age_value,
		output ready);
endinterface

FILE: hdl/page_table_with_aging_core.sv
`timescale 1ns / 1ps

// page table with 8-bit aging counters
// req channel: command, page, frame_in; rsp channel: hit, frame_out, frame_assigned,
// referenced, age_value; one rsp transaction for every req transaction, in order
// lookup, map, unmap and mark referenced: the accept cycle issues the entry read, the
// next cycle runs the update unit and, for map, unmap and mark referenced, writes the
// entry back over the single write port of the entry memory; a new req is taken the cycle after
// an age tick walks all min(PAGES, 256) entries through the same update unit, one
// entry per cycle with read and write-back overlapped
// the block is not ready during the walk
// the result goes to an output register; req is accepted while it waits, but the
// next write-back cycle holds until rsp takes the pending transaction
// arst_n clears the control state and one written flag per entry; an entry never
// written reads as all zero, so there is no clearing pass and the block is ready
// right after reset
// pages at or beyond PAGES return an all-zero result; an age tick returns all zero

module page_table_with_aging_core #(
	parameter int PAGES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	ptwa_req_if.sink  req,
	ptwa_rsp_if.source rsp
);
	import ptwa_pkg::*;

	localparam int DEPTH = (PAGES < PAGE_SPAN) ? PAGES : PAGE_SPAN;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE     = 4'b0001,
		S_MOD      = 4'b0010,
		S_AGE      = 4'b0100,
		S_AGE_DONE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CMD_W-1:0]   cmd_q;
	logic               page_ok_q;
	logic [AW-1:0]      addr_q;
	logic [FRAME_W-1:0] frame_q;
	logic [AW:0]        rd_cnt_q;
	logic               age_pend_s1;
	logic [AW-1:0]      age_addr_s1;
	logic               wr_flag_s1;
	logic [DEPTH-1:0]   written_q;
	logic               rsp_valid_q;
	result_t            rsp_q;

	logic               req_acc;
	logic               out_free;
	logic               rsp_load;
	logic               rd_more;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [EW-1:0]      ram_rdata;
	entry_t             ent_rd;
	entry_t             ent_new;
	logic [CMD_W-1:0]   upd_cmd;
	logic               cmd_writes;
	result_t            res;

	// shared update unit: the next entry state for one command
	function automatic entry_t update_entry(entry_t e, logic [CMD_W-1:0] cmd,
		logic [FRAME_W-1:0] frame);
		entry_t n;
		n = e;
		case (cmd)
			CMD_MAP: begin
				if (32'(frame) < FRAMES) begin
					n.valid      = 1'b1;
					n.has_frame  = 1'b1;
					n.frame      = frame;
					n.referenced = 1'b0;
					n.age        = '0;
				end
			end
			CMD_UNMAP: begin
				n.valid     = 1'b0;
				n.has_frame = 1'b0;
				n.frame     = '0;
			end
			CMD_REF: begin
				n.referenced = 1'b1;
			end
			CMD_AGE: begin
				if (e.valid) begin
					n.age        = {e.referenced, e.age[AGE_W-1:1]};
					n.referenced = 1'b0;
				end
			end
			default: begin
				n = e;
			end
		endcase
		return n;
	endfunction

	ptwa_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ent_new),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp_load  = out_free && ((state_q == S_MOD) || (state_q == S_AGE_DONE));
	assign rd_more   = (rd_cnt_q < (AW+1)'(DEPTH));

	// never written entries read as the reset value
	assign ent_rd  = wr_flag_s1 ? entry_t'(ram_rdata) : '0;
	assign upd_cmd = (state_q == S_AGE) ? CMD_AGE : cmd_q;
	assign ent_new = update_entry(ent_rd, upd_cmd, frame_q);

	always_comb begin
		case (cmd_q)
			CMD_MAP, CMD_UNMAP, CMD_REF: cmd_writes = 1'b1;
			default:                     cmd_writes = 1'b0;
		endcase
	end

	always_comb begin
		ram_raddr = req.page[AW-1:0];
		ram_waddr = addr_q;
		ram_we    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = req.page[AW-1:0];
			end
			S_MOD: begin
				// keep re-reading the same entry while the output stalls
				ram_raddr = addr_q;
				ram_we    = out_free && page_ok_q && cmd_writes;
			end
			S_AGE: begin
				ram_raddr = rd_cnt_q[AW-1:0];
				ram_waddr = age_addr_s1;
				ram_we    = age_pend_s1 && ent_rd.valid;
			end
			S_AGE_DONE: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		res = '0;
		if (page_ok_q) begin
			res.hit            = ent_new.valid;
			res.frame_out      = ent_new.has_frame ? ent_new.frame : '0;
			res.frame_assigned = ent_new.has_frame;
			res.referenced     = ent_new.referenced;
			res.age_value      = ent_new.age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_cnt_q    <= '0;
			age_pend_s1 <= 1'b0;
			written_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				written_q[ram_waddr] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						rd_cnt_q    <= '0;
						age_pend_s1 <= 1'b0;
						state_q     <= (req.command == CMD_AGE) ? S_AGE : S_MOD;
					end
				end
				S_MOD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_AGE: begin
					age_pend_s1 <= rd_more;
					if (rd_more) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end else if (!age_pend_s1) begin
						state_q <= S_AGE_DONE;
					end
				end
				S_AGE_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_flag_s1 <= written_q[ram_raddr];
		if (state_q == S_AGE) begin
			age_addr_s1 <= rd_cnt_q[AW-1:0];
		end
		if (req_acc) begin
			cmd_q     <= req.command;
			page_ok_q <= (req.command != CMD_AGE) && (32'(req.page) < 32'(PAGES));
			addr_q    <= req.page[AW-1:0];
			frame_q   <= req.frame_in;
		end
		if (state_q == S_MOD && out_free) begin
			rsp_q <= res;
		end else if (state_q == S_AGE_DONE && out_free) begin
			rsp_q <= '0;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.hit            = rsp_q.hit;
	assign rsp.frame_out      = rsp_q.frame_out;
	assign rsp.frame_assigned = rsp_q.frame_assigned;
	assign rsp.referenced     = rsp_q.referenced;
	assign rsp.age_value      = rsp_q.age_value;
endmodule

FILE: hdl/ptwa_ram.sv
`timescale 1ns / 1ps

module ptwa_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/ptwa_checker.sv
`timescale 1ns / 1ps

module ptwa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [ptwa_pkg::CMD_W-1:0]  req_command,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_hit,
	input logic [ptwa_pkg::FRAME_W-1:0] rsp_frame_out,
	input logic                        rsp_frame_assigned,
	input logic                        rsp_referenced,
	input logic [ptwa_pkg::AGE_W-1:0]  rsp_age_value
);
	import ptwa_pkg::*;

	// a stalled response keeps its valid and payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
		&& $stable(rsp_frame_out) && $stable(rsp_frame_assigned)
		&& $stable(rsp_referenced) && $stable(rsp_age_value))
		else $error("rsp changed while stalled");

	// ready drops after an accept, so the core takes one req at a time
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req ready right after a transaction");

	// per-page commands accepted into an empty output answer via S_MOD and the output register
	a_page_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_command != CMD_AGE && !rsp_valid |=> ##1 rsp_valid)
		else $error("per-page response late");

	// a stored frame implies a valid entry, and no frame reads as zero
	a_frame_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp_frame_assigned || rsp_hit)
		&& (rsp_frame_assigned || rsp_frame_out == '0))
		else $error("frame fields inconsistent");
endmodule

bind page_table_with_aging_core ptwa_checker u_ptwa_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_command       (req.command),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_hit           (rsp.hit),
	.rsp_frame_out     (rsp.frame_out),
	.rsp_frame_assigned(rsp.frame_assigned),
	.rsp_referenced    (rsp.referenced),
	.rsp_age_value     (rsp.age_value)
);
